// ===== design/pcrc_pkg.sv =====
// shared constants for the predictive climate relay controller
package pcrc_pkg;

  // window depth default
  localparam int WINDOW_DEPTH_DEF = 8;

  // field widths
  localparam int TEMP_W = 16;
  localparam int HUM_W  = 16;
  localparam int TIME_W = 32;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_TARGET    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HUM_TARGET     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BAND_FRACTION  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PREDICT_ENABLE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RELAY_HOLD     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HEATER_INV     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_HUMID_INV      = 3'd6;

  // register reset values
  localparam logic [15:0] RST_TEMP_TARGET   = 16'd2500;
  localparam logic [15:0] RST_HUM_TARGET    = 16'd5000;
  localparam logic [15:0] RST_BAND_FRACTION = 16'd2621;
  localparam logic        RST_PREDICT       = 1'b1;
  localparam logic [15:0] RST_RELAY_HOLD    = 16'd300;

  // band scale: one in 16-bit fraction units, as an 18-bit factor
  localparam logic [17:0] BAND_ONE = 18'h10000;

endpackage

// ===== design/predictive_climate_relay_controller.sv =====
// top level of the predictive climate relay controller
//
// channel   dir  handshake          contents
// s_*       in   s_tvalid/s_tready  sample: temperature, humidity, now_seconds
// m_*       out  m_tvalid/m_tready  result: relay states, pin levels, trends, blocked
// cfg_*     in   cfg_write          register index and write data, no read-back
//
// one sample per cycle sustained while the output is not stalled; a result passes
// through stage one (the accept edge reads the window entry), then the window write
// and sums, then the products, then the decision into the output register
// the window memory has a single write port and one read port; the entry being
// evicted is read in the accept cycle and the write in flight is forwarded
// rst is synchronous; window contents are not cleared, the fill count keeps
// unwritten entries out of the running sums, so no clearing pass is needed
// the pipeline stops only when the last stage holds a result and the output
// register is full and not being taken; until then requests keep flowing in
module predictive_climate_relay_controller #(
  parameter int WINDOW_DEPTH = pcrc_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // sample request
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // temperature[15:0], humidity[31:16], now_seconds[63:32]
  input  logic [63:0]                       s_tdata,
  // result
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // heater_on, humidifier_on, heater_pin_level, humidifier_pin_level,
  // temp_rising, hum_rising, heater_switch_blocked, zero pad
  output logic [7:0]                        m_tdata,
  // configuration
  input  logic                              cfg_write,
  input  logic [pcrc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pcrc_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W  = 17 + $clog2(WINDOW_DEPTH);
  localparam int MUL_W  = 17 + CNT_W;     // sample times count, plus sign
  localparam int BAND_W = 35;             // 17-bit target times 18-bit factor

  // configuration registers
  logic signed [15:0] temp_target;
  logic [15:0]        hum_target;
  logic [15:0]        band_fraction;
  logic               predict_enable;
  logic [15:0]        relay_hold_seconds;
  logic               heater_pin_invert;
  logic               humidifier_pin_invert;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_target           <= $signed(pcrc_pkg::RST_TEMP_TARGET);
      hum_target            <= pcrc_pkg::RST_HUM_TARGET;
      band_fraction         <= pcrc_pkg::RST_BAND_FRACTION;
      predict_enable        <= pcrc_pkg::RST_PREDICT;
      relay_hold_seconds    <= pcrc_pkg::RST_RELAY_HOLD;
      heater_pin_invert     <= 1'b0;
      humidifier_pin_invert <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        pcrc_pkg::REG_TEMP_TARGET:    temp_target           <= $signed(cfg_data);
        pcrc_pkg::REG_HUM_TARGET:     hum_target            <= cfg_data;
        pcrc_pkg::REG_BAND_FRACTION:  band_fraction         <= cfg_data;
        pcrc_pkg::REG_PREDICT_ENABLE: predict_enable        <= cfg_data[0];
        pcrc_pkg::REG_RELAY_HOLD:     relay_hold_seconds    <= cfg_data;
        pcrc_pkg::REG_HEATER_INV:     heater_pin_invert     <= cfg_data[0];
        pcrc_pkg::REG_HUMID_INV:      humidifier_pin_invert <= cfg_data[0];
        default: ;  // unknown index: ignored
      endcase
    end
  end

  // pipeline enable: stall only when a finished result cannot move out
  logic en;
  logic p_valid;

  assign en       = !(p_valid && m_tvalid && !m_tready);
  assign s_tready = en;

  // window stages
  logic                        w_valid;
  logic signed [15:0]          w_temp;
  logic [15:0]                 w_hum;
  logic [31:0]                 w_now;
  logic [CNT_W-1:0]            w_count;
  logic signed [SUM_W-1:0]     w_tsum, w_hsum;

  pcrc_window #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_window (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_accept (s_tvalid),
    .in_temp   ($signed(s_tdata[15:0])),
    .in_hum    (s_tdata[31:16]),
    .in_now    (s_tdata[63:32]),
    .out_valid (w_valid),
    .out_temp  (w_temp),
    .out_hum   (w_hum),
    .out_now   (w_now),
    .out_count (w_count),
    .out_tsum  (w_tsum),
    .out_hsum  (w_hsum)
  );

  // product stage: trend products and band thresholds
  logic signed [MUL_W-1:0]  cnt_s;
  logic signed [16:0]       t_tgt, h_tgt;
  logic                     t_lt_c, t_gt_c, h_lt_c, h_gt_c;
  logic signed [17:0]       t_fac, h_fac;

  logic signed [MUL_W-1:0]  p_tprod, p_hprod, p_tsum, p_hsum;
  logic signed [BAND_W-1:0] p_tband, p_hband;
  logic signed [15:0]       p_temp;
  logic [15:0]              p_hum;
  logic [31:0]              p_now;
  logic                     p_tlt, p_tgt, p_hlt, p_hgt;

  assign cnt_s  = $signed(MUL_W'(w_count));
  assign t_tgt  = 17'(temp_target);
  assign h_tgt  = $signed({1'b0, hum_target});
  assign t_lt_c = w_temp < temp_target;
  assign t_gt_c = w_temp > temp_target;
  assign h_lt_c = w_hum < hum_target;
  assign h_gt_c = w_hum > hum_target;
  // below target uses one minus the band, above uses one plus
  assign t_fac  = $signed(t_lt_c ? pcrc_pkg::BAND_ONE - {2'b00, band_fraction}
                                 : pcrc_pkg::BAND_ONE + {2'b00, band_fraction});
  assign h_fac  = $signed(h_lt_c ? pcrc_pkg::BAND_ONE - {2'b00, band_fraction}
                                 : pcrc_pkg::BAND_ONE + {2'b00, band_fraction});

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (en) begin
      p_valid <= w_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_tprod <= MUL_W'(w_temp) * cnt_s;
      p_hprod <= $signed(MUL_W'(w_hum)) * cnt_s;
      p_tsum  <= MUL_W'(w_tsum);
      p_hsum  <= MUL_W'(w_hsum);
      p_tband <= BAND_W'(t_tgt * t_fac);
      p_hband <= BAND_W'(h_tgt * h_fac);
      p_temp  <= w_temp;
      p_hum   <= w_hum;
      p_now   <= w_now;
      p_tlt   <= t_lt_c;
      p_tgt   <= t_gt_c;
      p_hlt   <= h_lt_c;
      p_hgt   <= h_gt_c;
    end
  end

  // decision stage
  function automatic logic decide(input logic pe, input logic lt, input logic gt,
                                  input logic rising, input logic vs_ge, input logic vs_le);
    logic on;
    on = 1'b0;
    if (!pe) begin
      on = lt;
    end else if (lt) begin
      on = !(rising && vs_ge);
    end else if (gt) begin
      on = !rising && vs_le;
    end
    return on;
  endfunction

  logic signed [BAND_W-1:0] t_shift, h_shift;
  logic        t_rise, h_rise, want_heat, want_hum, allow, blocked, heat_next;
  logic [31:0] elapsed;

  logic        heat_relay;
  logic [31:0] last_switch_time;
  logic        never_switched;

  // sample scaled by the band unit
  assign t_shift = $signed({{3{p_temp[15]}}, p_temp, 16'h0000});
  assign h_shift = $signed({3'b000, p_hum, 16'h0000});

  assign t_rise = p_tprod > p_tsum;
  assign h_rise = p_hprod > p_hsum;

  assign want_heat = decide(predict_enable, p_tlt, p_tgt, t_rise,
                            t_shift >= p_tband, t_shift <= p_tband);
  assign want_hum  = decide(predict_enable, p_hlt, p_hgt, h_rise,
                            h_shift >= p_hband, h_shift <= p_hband);

  // hold timer, elapsed wraps modulo 2^32
  assign elapsed   = p_now - last_switch_time;
  assign allow     = (elapsed > {16'h0000, relay_hold_seconds}) || never_switched;
  assign blocked   = (want_heat != heat_relay) && !allow;
  assign heat_next = blocked ? heat_relay : want_heat;

  always_ff @(posedge clk) begin
    if (rst) begin
      heat_relay       <= 1'b0;
      last_switch_time <= '0;
      never_switched   <= 1'b1;
    end else if (en && p_valid && (want_heat != heat_relay) && allow) begin
      heat_relay       <= want_heat;
      last_switch_time <= p_now;
      never_switched   <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en && p_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && p_valid) begin
      m_tdata <= {1'b0, blocked, h_rise, t_rise,
                  want_hum ^ humidifier_pin_invert, heat_next ^ heater_pin_invert,
                  want_hum, heat_next};
    end
  end

  // the input side only waits on a full, unread output register
  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready))
    else $error("input stalled without output backpressure");

  // a refused switch leaves the heater and its timestamp alone
  a_blocked_hold: assert property (@(posedge clk) disable iff (rst)
    (en && p_valid && blocked) |=> ($stable(heat_relay) && $stable(last_switch_time)))
    else $error("heater changed on a refused switch");

  // reported heater state matches the relay register once loaded
  a_heater_out: assert property (@(posedge clk) disable iff (rst)
    (en && p_valid) |=> (m_tdata[0] == heat_relay))
    else $error("heater output differs from relay state");

  // the first-switch exemption is used only once
  a_first_switch: assert property (@(posedge clk) disable iff (rst)
    !never_switched |=> !never_switched)
    else $error("first-switch flag set again");

endmodule

// ===== design/pcrc_window.sv =====
// sample window memory with running sums, read-modify-write over two stages
module pcrc_window #(
  parameter int WINDOW_DEPTH = pcrc_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   en,
  input  logic                                   in_accept,
  input  logic signed [pcrc_pkg::TEMP_W-1:0]     in_temp,
  input  logic        [pcrc_pkg::HUM_W-1:0]      in_hum,
  input  logic        [pcrc_pkg::TIME_W-1:0]     in_now,
  output logic                                   out_valid,
  output logic signed [pcrc_pkg::TEMP_W-1:0]     out_temp,
  output logic        [pcrc_pkg::HUM_W-1:0]      out_hum,
  output logic        [pcrc_pkg::TIME_W-1:0]     out_now,
  output logic        [$clog2(WINDOW_DEPTH+1)-1:0] out_count,
  output logic signed [16+$clog2(WINDOW_DEPTH):0]  out_tsum,
  output logic signed [16+$clog2(WINDOW_DEPTH):0]  out_hsum
);

  localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int SUM_W  = 17 + $clog2(WINDOW_DEPTH);
  localparam int ENT_W  = pcrc_pkg::TEMP_W + pcrc_pkg::HUM_W;
  localparam logic [CNT_W-1:0]  DEPTH_CNT = CNT_W'(WINDOW_DEPTH);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_DEPTH - 1);

  // entry: humidity high, temperature low
  logic [ENT_W-1:0] mem [WINDOW_DEPTH];
  logic [ENT_W-1:0] rd_data;

  // allocation side
  logic [SLOT_W-1:0] slot;
  logic [CNT_W-1:0]  count;
  logic              full;

  // stage one
  logic                            s1_valid;
  logic signed [pcrc_pkg::TEMP_W-1:0] s1_temp;
  logic [pcrc_pkg::HUM_W-1:0]      s1_hum;
  logic [pcrc_pkg::TIME_W-1:0]     s1_now;
  logic [SLOT_W-1:0]               s1_slot;
  logic                            s1_full;
  logic [CNT_W-1:0]                s1_count;
  logic                            fwd_hit;
  logic [ENT_W-1:0]                fwd_data;

  logic [ENT_W-1:0]                   evict;
  logic signed [pcrc_pkg::TEMP_W-1:0] ev_temp;
  logic [pcrc_pkg::HUM_W-1:0]         ev_hum;
  logic signed [SUM_W-1:0]            tsum, hsum, tsum_next, hsum_next;

  assign full = (count == DEPTH_CNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      slot  <= '0;
      count <= '0;
    end else if (en && in_accept) begin
      slot <= (slot == LAST_SLOT) ? '0 : slot + 1'b1;
      if (!full) begin
        count <= count + 1'b1;
      end
    end
  end

  // read the entry about to be overwritten; forward the write in flight
  always_ff @(posedge clk) begin
    if (en && in_accept) begin
      rd_data  <= mem[slot];
      fwd_hit  <= s1_valid && (s1_slot == slot);
      fwd_data <= {s1_hum, s1_temp};
    end
  end

  always_ff @(posedge clk) begin
    if (en && s1_valid) begin
      mem[s1_slot] <= {s1_hum, s1_temp};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_temp  <= in_temp;
      s1_hum   <= in_hum;
      s1_now   <= in_now;
      s1_slot  <= slot;
      s1_full  <= full;
      s1_count <= full ? count : count + 1'b1;
    end
  end

  assign evict   = fwd_hit ? fwd_data : rd_data;
  assign ev_temp = $signed(evict[pcrc_pkg::TEMP_W-1:0]);
  assign ev_hum  = evict[ENT_W-1:pcrc_pkg::TEMP_W];

  always_comb begin
    tsum_next = tsum + SUM_W'(s1_temp);
    hsum_next = hsum + $signed(SUM_W'(s1_hum));
    if (s1_full) begin
      tsum_next = tsum_next - SUM_W'(ev_temp);
      hsum_next = hsum_next - $signed(SUM_W'(ev_hum));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tsum <= '0;
      hsum <= '0;
    end else if (en && s1_valid) begin
      tsum <= tsum_next;
      hsum <= hsum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_temp  <= s1_temp;
      out_hum   <= s1_hum;
      out_now   <= s1_now;
      out_count <= s1_count;
      out_tsum  <= tsum_next;
      out_hsum  <= hsum_next;
    end
  end

endmodule

// ===== bench/tb_predictive_climate_relay_controller.sv =====
`timescale 1ns / 100ps
// self-checking bench for the predictive climate relay controller
module tb_predictive_climate_relay_controller;

  localparam int DEPTH         = pcrc_pkg::WINDOW_DEPTH_DEF;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_SAMPLES = 100;
  localparam int REPORT_MAX    = 10;
  localparam int LATENCY_TAIL  = 12;
  localparam longint BAND_UNITS = 65536;

  // index past the end of the register list, writes to it must be dropped
  localparam logic [pcrc_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

  // result fields in m_tdata, lowest bit first
  localparam int F_HEAT_ON    = 0;
  localparam int F_HUM_ON     = 1;
  localparam int F_HEAT_PIN   = 2;
  localparam int F_HUM_PIN    = 3;
  localparam int F_TEMP_RISE  = 4;
  localparam int F_HUM_RISE   = 5;
  localparam int F_BLOCKED    = 6;
  localparam int NUM_FIELDS   = 7;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [63:0]          s_tdata = '0;   // temperature[15:0], humidity[31:16], now_seconds[63:32]
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [7:0]           m_tdata;        // heater_on, humidifier_on, heater pin, humidifier pin,
                                        // temp_rising, hum_rising, switch_blocked, zero pad
  logic                 cfg_write = 1'b0;
  logic [pcrc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [pcrc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  always #4 clk = ~clk;

  predictive_climate_relay_controller #(.WINDOW_DEPTH(DEPTH)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // controller model: window, sums, relay states and its own register copies
  // ---------------------------------------------------------------------------
  logic signed [15:0] temp_hist [DEPTH];
  logic [15:0]        hum_hist  [DEPTH];
  int                 fill_count;
  int                 fill_slot;
  longint             temp_total;
  longint             hum_total;
  bit                 heater_now;
  bit                 humidifier_now;
  bit                 never_switched_yet;
  logic [31:0]        last_switch_at;

  logic signed [15:0] temp_setpoint;
  logic [15:0]        hum_setpoint;
  logic [15:0]        band_frac;
  logic [15:0]        hold_secs;
  bit                 anticipate;
  bit                 heater_inv;
  bit                 humid_inv;

  // relay words still owed by the block, oldest first
  logic [NUM_FIELDS-1:0] pending_relay_words [$];

  int          cycles;
  int          mismatches;
  int          samples_sent;
  int          results_seen;
  int          reg_writes;
  int          stall_left;
  bit          no_idle;
  logic [31:0] clock_secs;

  task automatic reset_model();
    for (int i = 0; i < DEPTH; i++) begin
      temp_hist[i] = '0;
      hum_hist[i]  = '0;
    end
    fill_count         = 0;
    fill_slot          = 0;
    temp_total         = 0;
    hum_total          = 0;
    heater_now         = 1'b0;
    humidifier_now     = 1'b0;
    never_switched_yet = 1'b1;
    last_switch_at     = '0;
    temp_setpoint      = pcrc_pkg::RST_TEMP_TARGET;
    hum_setpoint       = pcrc_pkg::RST_HUM_TARGET;
    band_frac          = pcrc_pkg::RST_BAND_FRACTION;
    anticipate         = pcrc_pkg::RST_PREDICT;
    hold_secs          = pcrc_pkg::RST_RELAY_HOLD;
    heater_inv         = 1'b0;
    humid_inv          = 1'b0;
  endtask

  // wanted relay state for one quantity; inside the band the trend decides early
  function automatic bit want_on(longint value, longint target, bit rising);
    longint lo_bound;
    longint hi_bound;
    if (!anticipate)
      return value < target;
    if (value < target) begin
      lo_bound = target * (BAND_UNITS - longint'(band_frac));
      return !(rising && value * BAND_UNITS >= lo_bound);
    end
    if (value > target) begin
      hi_bound = target * (BAND_UNITS + longint'(band_frac));
      return !rising && value * BAND_UNITS <= hi_bound;
    end
    return 1'b0;
  endfunction

  // push one sample through the model and return the relay word it produces
  function automatic logic [NUM_FIELDS-1:0] predict_relays(logic signed [15:0] temp,
                                                           logic [15:0] hum,
                                                           logic [31:0] stamp);
    int                    slot;
    bit                    t_rise;
    bit                    h_rise;
    bit                    want_heat;
    bit                    want_hum;
    bit                    blocked;
    logic [31:0]           elapsed;
    logic [NUM_FIELDS-1:0] word;
    slot    = fill_slot;
    blocked = 1'b0;
    // only a full window drops its oldest entry
    if (fill_count >= DEPTH) begin
      temp_total -= longint'(temp_hist[slot]);
      hum_total  -= longint'(hum_hist[slot]);
    end else begin
      fill_count++;
    end
    temp_hist[slot] = temp;
    hum_hist[slot]  = hum;
    temp_total += longint'(temp);
    hum_total  += longint'(hum);
    fill_slot = (slot + 1) % DEPTH;

    // above the mean, compared without division
    t_rise = longint'(temp) * fill_count > temp_total;
    h_rise = longint'(hum) * fill_count > hum_total;

    want_heat = want_on(longint'(temp), longint'(temp_setpoint), t_rise);
    want_hum  = want_on(longint'(hum), longint'(hum_setpoint), h_rise);

    // heater obeys the hold time except on its very first change
    if (want_heat != heater_now) begin
      elapsed = stamp - last_switch_at;
      if (elapsed > {16'd0, hold_secs} || never_switched_yet) begin
        heater_now         = want_heat;
        last_switch_at     = stamp;
        never_switched_yet = 1'b0;
      end else begin
        blocked = 1'b1;
      end
    end
    humidifier_now = want_hum;

    word[F_HEAT_ON]   = heater_now;
    word[F_HUM_ON]    = humidifier_now;
    word[F_HEAT_PIN]  = heater_now ^ heater_inv;
    word[F_HUM_PIN]   = humidifier_now ^ humid_inv;
    word[F_TEMP_RISE] = t_rise;
    word[F_HUM_RISE]  = h_rise;
    word[F_BLOCKED]   = blocked;
    return word;
  endfunction

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------
  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55)
      return 0;
    if (r < 90)
      return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // one sample request; leaves tvalid high so the next request can follow at once
  task automatic send_sample(logic signed [15:0] temp, logic [15:0] hum, logic [31:0] stamp);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {stamp, hum, temp};
    do @(posedge clk); while (!s_tready);
    pending_relay_words.push_back(predict_relays(temp, hum, stamp));
    samples_sent++;
  endtask

  // stop requesting and wait until every owed result has been taken
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_relay_words.size() != 0);
  endtask

  task automatic write_reg(logic [pcrc_pkg::CFG_IDX_W-1:0] idx, logic [15:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    case (idx)
      pcrc_pkg::REG_TEMP_TARGET:    temp_setpoint = value;
      pcrc_pkg::REG_HUM_TARGET:     hum_setpoint  = value;
      pcrc_pkg::REG_BAND_FRACTION:  band_frac     = value;
      pcrc_pkg::REG_PREDICT_ENABLE: anticipate    = value[0];
      pcrc_pkg::REG_RELAY_HOLD:     hold_secs     = value;
      pcrc_pkg::REG_HEATER_INV:     heater_inv    = value[0];
      pcrc_pkg::REG_HUMID_INV:      humid_inv     = value[0];
      default: ;
    endcase
    reg_writes++;
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_settings(logic [15:0] temp_t, logic [15:0] hum_t, logic [15:0] band,
                                logic [15:0] predict, logic [15:0] hold,
                                logic [15:0] heat_inv, logic [15:0] hum_inv);
    write_reg(pcrc_pkg::REG_TEMP_TARGET, temp_t);
    write_reg(pcrc_pkg::REG_HUM_TARGET, hum_t);
    write_reg(pcrc_pkg::REG_BAND_FRACTION, band);
    write_reg(pcrc_pkg::REG_PREDICT_ENABLE, predict);
    write_reg(pcrc_pkg::REG_RELAY_HOLD, hold);
    write_reg(pcrc_pkg::REG_HEATER_INV, heat_inv);
    write_reg(pcrc_pkg::REG_HUMID_INV, hum_inv);
  endtask

  // result side stalls: mostly ready, short stalls, now and then a long one
  always @(posedge clk) begin
    if (no_idle) begin
      m_tready <= 1'b1;
    end else if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 99) < 75) begin
      m_tready <= 1'b1;
    end else begin
      m_tready   <= 1'b0;
      stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2) : $urandom_range(5, 30);
    end
  end

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------
  function automatic string field_label(int i);
    case (i)
      F_HEAT_ON:   return "heater_on";
      F_HUM_ON:    return "humidifier_on";
      F_HEAT_PIN:  return "heater_pin_level";
      F_HUM_PIN:   return "humidifier_pin_level";
      F_TEMP_RISE: return "temp_rising";
      F_HUM_RISE:  return "hum_rising";
      F_BLOCKED:   return "heater_switch_blocked";
      default:     return "pad";
    endcase
  endfunction

  task automatic flag_error(string msg);
    mismatches++;
    if (mismatches <= REPORT_MAX)
      $display("[%0t] %s", $realtime, msg);
  endtask

  always @(posedge clk) begin : result_check
    logic [NUM_FIELDS-1:0] owed;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (pending_relay_words.size() == 0) begin
        flag_error($sformatf("result %0d with no sample pending, got %b",
                             results_seen, m_tdata));
      end else begin
        owed = pending_relay_words.pop_front();
        for (int i = 0; i < NUM_FIELDS; i++)
          if (m_tdata[i] !== owed[i])
            flag_error($sformatf("result %0d %s: expected %b, got %b",
                                 results_seen, field_label(i), owed[i], m_tdata[i]));
      end
    end
  end

  // hard stop if the block hangs
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  // reset settings: at-target, first switch, hold refusal, timer wrap, field extremes
  task automatic test_field_extremes();
    send_sample(16'sd2500, 16'd5000, 32'd0);            // exactly at both targets
    send_sample(16'sh8000, 16'd0, 32'd5);               // first heater change ignores hold
    send_sample(16'sd32767, 16'hFFFF, 32'd6);           // change wanted, hold refuses it
    send_sample(16'sd0, 16'd0, 32'hFFFF_FF00);
    send_sample(16'sd32767, 16'hFFFF, 32'hFFFF_FF80);
    send_sample(16'sh8000, 16'd0, 32'h0000_0010);       // across the wrap, still inside hold
    send_sample(16'sh8000, 16'd0, 32'h0000_0030);       // across the wrap, hold still not over
    send_sample(-16'sd1, 16'h8000, 32'h8000_0000);
    clock_secs = 32'h8000_0000;
  endtask

  // ramps into the band from below and above so the trend switches early
  task automatic test_band_anticipation();
    for (int i = 0; i < 7; i++) begin
      clock_secs += 400;
      send_sample(16'(2380 + i * 18), 16'(4780 + i * 35), clock_secs);
    end
    for (int i = 0; i < 4; i++) begin
      clock_secs += 400;
      send_sample(16'(2620 - i * 33), 16'(5220 - i * 70), clock_secs);
    end
    clock_secs += 400;
    send_sample(16'sd2500, 16'd5000, clock_secs);
  endtask

  // negative target, band and hold extremes, inverted pins, masked and dropped writes
  task automatic test_register_extremes();
    settle();
    apply_settings(-16'sd1000, 16'd0, 16'hFFFF, 16'd1, 16'd0, 16'hFFFF, 16'd1);
    write_reg(REG_UNMAPPED, 16'h1234);
    send_sample(-16'sd1500, 16'd0, clock_secs);
    send_sample(-16'sd1000, 16'd1, clock_secs);        // zero hold, same second: refused
    send_sample(-16'sd500, 16'd0, clock_secs + 1);
    send_sample(-16'sd1990, 16'd3, clock_secs + 2);
    send_sample(-16'sd10, 16'd0, clock_secs + 3);
    settle();
    write_reg(pcrc_pkg::REG_PREDICT_ENABLE, 16'h0002); // only bit 0 counts: plain thresholds
    write_reg(pcrc_pkg::REG_BAND_FRACTION, 16'd0);
    send_sample(-16'sd1000, 16'd0, clock_secs + 10);
    send_sample(-16'sd1001, 16'd0, clock_secs + 20);
    send_sample(-16'sd999, 16'd1, clock_secs + 30);
    clock_secs += 30;
  endtask

  // several settings, walks and jumps around the targets with random timestamps
  task automatic test_random_phases();
    int          r;
    int          span_t;
    int          span_h;
    int          walk_temp;
    int          walk_hum;
    logic [15:0] pick_t;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      settle();
      case (phase)
        0: apply_settings(16'd2500, 16'd5000, 16'd2621, 16'd1, 16'd300, 16'd0, 16'd0);
        1: apply_settings(16'h7FFF, 16'hFFFF, 16'hFFFF, 16'd1, 16'd0, 16'd1, 16'd0);
        2: apply_settings(16'h8000, 16'd0, 16'd0, 16'd1, 16'hFFFF, 16'd0, 16'd1);
        3: apply_settings(16'($urandom_range(0, 6000)), 16'($urandom_range(0, 9000)),
                          16'($urandom), 16'd0, 16'($urandom_range(0, 200)),
                          16'($urandom_range(0, 1)), 16'($urandom_range(0, 1)));
        default: begin
          pick_t = ($urandom_range(0, 99) < 20) ? 16'($urandom)
                                                : 16'(int'($urandom_range(0, 6000)) - 1000);
          apply_settings(pick_t, 16'($urandom_range(0, 10000)), 16'($urandom),
                         16'($urandom), 16'($urandom_range(0, 600)),
                         16'($urandom), 16'($urandom));
        end
      endcase
      // one phase runs with no idling on either side
      no_idle = (phase == 4);

      span_t = int'(longint'(temp_setpoint < 0 ? -int'(temp_setpoint) : int'(temp_setpoint))
                    * band_frac / BAND_UNITS) + 30;
      span_h = int'(longint'(hum_setpoint) * band_frac / BAND_UNITS) + 30;
      walk_temp = int'(temp_setpoint);
      walk_hum  = int'(hum_setpoint);

      for (int n = 0; n < PHASE_SAMPLES; n++) begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          walk_temp += int'($urandom_range(0, 80)) - 40;
          walk_hum  += int'($urandom_range(0, 80)) - 40;
        end else if (r < 85) begin
          walk_temp = int'(temp_setpoint) + int'($urandom_range(0, 2 * span_t)) - span_t;
          walk_hum  = int'(hum_setpoint) + int'($urandom_range(0, 2 * span_h)) - span_h;
        end else begin
          walk_temp = int'($urandom_range(0, 65535)) - 32768;
          walk_hum  = int'($urandom_range(0, 65535));
        end
        if (walk_temp > 32767)  walk_temp = 32767;
        if (walk_temp < -32768) walk_temp = -32768;
        if (walk_hum > 65535)   walk_hum = 65535;
        if (walk_hum < 0)       walk_hum = 0;

        r = $urandom_range(0, 99);
        if (r < 75)
          clock_secs += $urandom_range(0, hold_secs / 3 + 3);
        else if (r < 90)
          clock_secs += $urandom_range(hold_secs, hold_secs + 50);
        else if (r < 95)
          clock_secs = $urandom;
        else
          clock_secs = 32'hFFFF_FFFF - $urandom_range(0, 200);

        send_sample(16'(walk_temp), 16'(walk_hum), clock_secs);
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    reset_model();
    clock_secs = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_field_extremes();
    test_band_anticipation();
    test_register_extremes();
    test_random_phases();

    // everything owed has arrived; watch a little longer for stray results
    settle();
    repeat (LATENCY_TAIL) @(posedge clk);

    $display("covered %0d sample requests, %0d results checked, %0d register writes",
             samples_sent, results_seen, reg_writes);
    $display("field mismatches and stray results: %0d", mismatches);
    if (mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== predictive_climate_relay_controller.f =====
design/pcrc_pkg.sv
design/pcrc_window.sv
design/predictive_climate_relay_controller.sv
bench/tb_predictive_climate_relay_controller.sv
